### hw/rtl/mpeg_ps_pes_header_parser_unit_assert.svh
// assertion macros used by the parser top level
`ifndef MPEG_PS_PES_HEADER_PARSER_UNIT_ASSERT_SVH
`define MPEG_PS_PES_HEADER_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising edge outside reset
`define MPSPH_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MPSPH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPSPH_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define MPSPH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/mpsph_pkg.sv
// types and constants of the program stream pes header parser
package mpsph_pkg;

  typedef enum logic [4:0] {
    PH_SEARCH,
    PH_SKIPLEN_H,
    PH_SKIPLEN_L,
    PH_LEN_H,
    PH_LEN_L,
    PH_STUFF,
    PH_BUF1,
    PH_BUF2,
    PH_M2FLAGS,
    PH_M2HLEN,
    PH_PTS,
    PH_DTS,
    PH_M2SKIP,
    PH_SUBID,
    PH_SUBSKIP,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_SYNC_LOST = 2'd2
  } kind_t;

  localparam logic [16:0] SYNC_LIMIT_RESET = 17'd100000;
  localparam logic [23:0] WINDOW_RESET     = 24'h0000ff;
  localparam logic [23:0] START_PREFIX     = 24'h000001;

  typedef struct packed {
    logic [23:0] scan_window;
    logic [16:0] scan_count;
    phase_t      phase;
    logic [15:0] packet_remaining;
    logic [7:0]  header_remaining;
    logic [7:0]  pes_flags;
    logic [3:0]  field_byte_count;
    logic [32:0] pts_acc;
    logic [32:0] dts_acc;
    logic [8:0]  current_code;
  } state_t;

  localparam state_t STATE_RESET = '{
    scan_window:      WINDOW_RESET,
    scan_count:       17'd0,
    phase:            PH_SEARCH,
    packet_remaining: 16'd0,
    header_remaining: 8'd0,
    pes_flags:        8'd0,
    field_byte_count: 4'd0,
    pts_acc:          33'd0,
    dts_acc:          33'd0,
    current_code:     9'd0
  };

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  stream_id;
    logic        is_substream;
    logic [32:0] pts;
    logic [32:0] dts;
    logic        pts_valid;
    logic        dts_valid;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

### hw/rtl/mpsph_step.sv
// per-byte parser transition: next state and optional result
module mpsph_step
  import mpsph_pkg::*;
(
  input  state_t      cur,
  input  logic [7:0]  data_byte,
  input  logic [16:0] sync_limit,
  output state_t      nxt,
  output logic        res_valid,
  output result_t     res
);

  // timestamp byte feed, marker bits dropped
  function automatic logic [32:0] ts_feed(input logic [32:0] acc, input logic [2:0] idx,
                                          input logic [7:0] b);
    logic [32:0] r;
    case (idx)
      3'd0:         r = {30'd0, b[3:1]};
      3'd1, 3'd3:   r = {acc[24:0], b};
      default:      r = {acc[25:0], b[7:1]};
    endcase
    return r;
  endfunction

  state_t      s;
  logic        do_classify;
  logic        allow_buf;
  logic        do_after_ts;
  logic        do_post;
  logic        do_emit;
  logic        do_resync;
  logic [16:0] limit;
  logic [15:0] pr_need;
  logic [7:0]  hr_need;
  logic [3:0]  fbc_inc;
  logic [32:0] ts_val;

  assign limit   = (sync_limit == 17'd0) ? 17'd1 : sync_limit;
  assign fbc_inc = cur.field_byte_count + 4'd1;

  always_comb begin
    s           = cur;
    res         = '0;
    res_valid   = 1'b0;
    do_classify = 1'b0;
    allow_buf   = 1'b0;
    do_after_ts = 1'b0;
    do_post     = 1'b0;
    do_emit     = 1'b0;
    do_resync   = 1'b0;
    pr_need     = 16'd0;
    hr_need     = 8'd0;
    ts_val      = 33'd0;

    case (cur.phase)
      PH_SEARCH: begin
        s.scan_window = {cur.scan_window[15:0], data_byte};
        s.scan_count  = cur.scan_count + 17'd1;
        if (cur.scan_window == START_PREFIX) begin
          s.current_code = {1'b1, data_byte};
          if (data_byte == 8'hbe || data_byte == 8'hbf) begin
            s.phase = PH_SKIPLEN_H;
          end else if ((data_byte >= 8'hc0 && data_byte <= 8'hef) || data_byte == 8'hbd) begin
            s.phase = PH_LEN_H;
          end else begin
            do_resync = 1'b1;
          end
        end else if (s.scan_count >= limit) begin
          res.kind  = KIND_SYNC_LOST;
          res_valid = 1'b1;
          do_resync = 1'b1;
        end
      end
      PH_SKIPLEN_H: s.phase = PH_SKIPLEN_L;
      PH_SKIPLEN_L: do_resync = 1'b1;
      PH_LEN_H: begin
        s.packet_remaining = {data_byte, 8'h00};
        s.phase            = PH_LEN_L;
      end
      PH_LEN_L: begin
        s.packet_remaining = {cur.packet_remaining[15:8], data_byte};
        s.pes_flags        = 8'd0;
        if (s.packet_remaining == 16'd0) begin
          do_resync = 1'b1;
        end else begin
          s.phase = PH_STUFF;
        end
      end
      PH_STUFF: begin
        s.packet_remaining = cur.packet_remaining - 16'd1;
        if (data_byte == 8'hff) begin
          if (s.packet_remaining == 16'd0) begin
            do_resync = 1'b1;
          end
        end else begin
          do_classify = 1'b1;
          allow_buf   = 1'b1;
        end
      end
      PH_BUF1: s.phase = PH_BUF2;
      PH_BUF2: do_classify = 1'b1;
      PH_M2FLAGS: begin
        s.pes_flags = {data_byte[7], data_byte[7] & data_byte[6], 5'd0, 1'b1};
        s.phase     = PH_M2HLEN;
      end
      PH_M2HLEN: begin
        if (cur.packet_remaining < 16'd2 ||
            {8'd0, data_byte} > (cur.packet_remaining - 16'd2)) begin
          do_resync = 1'b1;
        end else begin
          s.packet_remaining = cur.packet_remaining - 16'd2 - {8'd0, data_byte};
          s.header_remaining = data_byte;
          if (cur.pes_flags[7]) begin
            s.field_byte_count = 4'd0;
            s.phase            = PH_PTS;
          end else begin
            do_after_ts = 1'b1;
          end
        end
      end
      PH_PTS: begin
        ts_val             = ts_feed(cur.pts_acc, cur.field_byte_count[2:0], data_byte);
        s.pts_acc          = ts_val;
        s.field_byte_count = fbc_inc;
        if (fbc_inc >= 4'd5) begin
          if (cur.pes_flags[6]) begin
            s.field_byte_count = 4'd0;
            s.phase            = PH_DTS;
          end else begin
            s.dts_acc   = ts_val;
            do_after_ts = 1'b1;
          end
        end
      end
      PH_DTS: begin
        s.dts_acc          = ts_feed(cur.dts_acc, cur.field_byte_count[2:0], data_byte);
        s.field_byte_count = fbc_inc;
        if (fbc_inc >= 4'd5) begin
          do_after_ts = 1'b1;
        end
      end
      PH_M2SKIP: begin
        s.header_remaining = cur.header_remaining - 8'd1;
        if (s.header_remaining == 8'd0) begin
          do_post = 1'b1;
        end
      end
      PH_SUBID: begin
        s.packet_remaining = cur.packet_remaining - 16'd1;
        s.current_code     = {1'b0, data_byte};
        if (data_byte[7:6] == 2'b10) begin
          if (s.packet_remaining < 16'd3) begin
            do_resync = 1'b1;
          end else begin
            s.packet_remaining = s.packet_remaining - 16'd3;
            s.field_byte_count = 4'd0;
            s.phase            = PH_SUBSKIP;
          end
        end else begin
          do_emit = 1'b1;
        end
      end
      PH_SUBSKIP: begin
        s.field_byte_count = fbc_inc;
        if (fbc_inc >= 4'd3) begin
          do_emit = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        s.packet_remaining = cur.packet_remaining - 16'd1;
        res.kind           = KIND_PAYLOAD;
        res.stream_id      = cur.current_code[7:0];
        res.is_substream   = ~cur.current_code[8];
        res.payload_byte   = data_byte;
        res.last           = (s.packet_remaining == 16'd0);
        res_valid          = 1'b1;
        if (s.packet_remaining == 16'd0) begin
          do_resync = 1'b1;
        end
      end
      default: do_resync = 1'b1;
    endcase

    // mpeg-1 buffer, stamp or no-stamp flags byte, or mpeg-2 marker
    if (do_classify) begin
      if (allow_buf && data_byte[7:6] == 2'b01) begin
        if (s.packet_remaining < 16'd2) begin
          do_resync = 1'b1;
        end else begin
          s.packet_remaining = s.packet_remaining - 16'd2;
          s.phase            = PH_BUF1;
        end
      end else if (data_byte[7:5] == 3'b001) begin
        pr_need = data_byte[4] ? 16'd9 : 16'd4;
        if (s.packet_remaining < pr_need) begin
          do_resync = 1'b1;
        end else begin
          s.packet_remaining = s.packet_remaining - pr_need;
          s.pes_flags        = data_byte[4] ? 8'hc0 : 8'h80;
          s.pts_acc          = ts_feed(33'd0, 3'd0, data_byte);
          s.field_byte_count = 4'd1;
          s.phase            = PH_PTS;
        end
      end else if (data_byte[7:6] == 2'b10) begin
        s.phase = PH_M2FLAGS;
      end else if (data_byte == 8'h0f) begin
        s.pes_flags = 8'd0;
        do_post     = 1'b1;
      end else begin
        do_resync = 1'b1;
      end
    end

    // mpeg-2 header length accounting after timestamps
    if (do_after_ts) begin
      if (s.pes_flags[0]) begin
        hr_need = s.pes_flags[6] ? 8'd10 : (s.pes_flags[7] ? 8'd5 : 8'd0);
        if (s.header_remaining < hr_need) begin
          do_resync = 1'b1;
        end else begin
          s.header_remaining = s.header_remaining - hr_need;
          if (s.header_remaining != 8'd0) begin
            s.phase = PH_M2SKIP;
          end else begin
            do_post = 1'b1;
          end
        end
      end else begin
        do_post = 1'b1;
      end
    end

    // private stream 1 carries a substream id first
    if (do_post) begin
      if (s.current_code == 9'h1bd) begin
        if (s.packet_remaining == 16'd0) begin
          do_resync = 1'b1;
        end else begin
          s.phase = PH_SUBID;
        end
      end else begin
        do_emit = 1'b1;
      end
    end

    if (do_emit) begin
      res.kind           = KIND_HEADER;
      res.stream_id      = s.current_code[7:0];
      res.is_substream   = ~s.current_code[8];
      res.pts_valid      = s.pes_flags[7];
      res.dts_valid      = s.pes_flags[7];
      res.pts            = s.pes_flags[7] ? s.pts_acc : 33'd0;
      res.dts            = s.pes_flags[7] ? s.dts_acc : 33'd0;
      res.payload_length = s.packet_remaining;
      res.last           = (s.packet_remaining == 16'd0);
      res_valid          = 1'b1;
      if (s.packet_remaining == 16'd0) begin
        do_resync = 1'b1;
      end else begin
        s.phase = PH_PAYLOAD;
      end
    end

    if (do_resync) begin
      s.phase       = PH_SEARCH;
      s.scan_window = WINDOW_RESET;
      s.scan_count  = 17'd0;
    end

    nxt = s;
  end

endmodule

### hw/rtl/mpeg_ps_pes_header_parser_unit.sv
// top level of the program stream pes header parser
//
// usage: program stream bytes enter on the s_axis channel, one item per byte.
// results leave on m_axis: a header record per audio, video or private-1
// packet, then its payload bytes (tlast on the final item of the packet),
// or a sync-lost item when sync_limit bytes pass without a start code.
// packets of other kinds are skipped and produce no item.
// sync_limit is written over the cfg channel (always ready); the user must
// write it only while idle, the block itself does not enforce this.
// path: an accepted byte lands in the input register, is parsed once the
// result register is free, and its result is then held on m_axis.
// throughput: one byte per cycle while m_axis is not stalled, set by the
// combinational parse step between the input and the result register.
// a stalled receiver holds the result register; an empty input register still
// takes one more byte, then s_axis_tready drops until the result is taken.
// reset: synchronous, clears both valid flags, puts the parser back into
// start code search with a clear window and sets sync_limit to 100000.
`include "mpeg_ps_pes_header_parser_unit_assert.svh"

module mpeg_ps_pes_header_parser_unit
  import mpsph_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // stream bytes in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  // results out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // stream_id[7:0], pts[40:8], dts[73:41], pts_valid[74], dts_valid[75],
  // payload_length[91:76], payload_byte[99:92], zero pad[103:100]
  output logic [103:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // kind[1:0], is_substream[2]
  output logic         m_axis_tlast,
  // sync_limit register write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;
  logic        proc;
  logic [16:0] sync_limit;
  state_t      state;
  state_t      state_next;
  logic        step_valid;
  result_t     step_res;
  logic        out_valid;
  result_t     out_res;

  // result register frees up when empty or being taken
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign proc          = in_valid && advance;
  assign cfg_ready     = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_limit <= SYNC_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_limit <= cfg_data;
    end
  end

  // parse step
  mpsph_step u_step (
    .cur        (state),
    .data_byte  (in_byte),
    .sync_limit (sync_limit),
    .nxt        (state_next),
    .res_valid  (step_valid),
    .res        (step_res)
  );

  // parser state advances once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (proc) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= proc && step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && step_valid) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res.payload_byte, out_res.payload_length,
                          out_res.dts_valid, out_res.pts_valid, out_res.dts,
                          out_res.pts, out_res.stream_id};
  assign m_axis_tuser  = {out_res.is_substream, out_res.kind};
  assign m_axis_tlast  = out_res.last;

  // checks
  `MPSPH_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !advance,
    in_valid && $stable(in_byte), "input register lost a byte while stalled")
  `MPSPH_ASSERT_IMPLY(a_sync_lost_not_last, clk, rst,
    out_valid && out_res.kind == KIND_SYNC_LOST, !out_res.last,
    "sync-lost item marked last")
  `MPSPH_ASSERT_IMPLY(a_header_last, clk, rst,
    out_valid && out_res.kind == KIND_HEADER,
    out_res.last == (out_res.payload_length == 16'd0),
    "header last mark disagrees with payload length")
  `MPSPH_ASSERT_IMPLY(a_payload_no_ts, clk, rst,
    out_valid && out_res.kind == KIND_PAYLOAD,
    !out_res.pts_valid && !out_res.dts_valid && out_res.payload_length == 16'd0,
    "payload item carries header fields")

endmodule

### dv/mpeg_ps_pes_header_parser_unit_test.sv
// testbench of the pes header parser, checked against a byte-level predictor
module mpeg_ps_pes_header_parser_unit_test
  import mpsph_pkg::*;
();

  // stream ids used to build packets
  localparam logic [7:0] SID_PACK          = 8'hba;
  localparam logic [7:0] SID_SYSTEM        = 8'hbb;
  localparam logic [7:0] SID_MAP           = 8'hbc;
  localparam logic [7:0] SID_PRIVATE_1     = 8'hbd;
  localparam logic [7:0] SID_PADDING       = 8'hbe;
  localparam logic [7:0] SID_PRIVATE_2     = 8'hbf;
  localparam logic [7:0] SID_AUDIO_FIRST   = 8'hc0;
  localparam logic [7:0] SID_VIDEO_FIRST   = 8'he0;
  localparam logic [7:0] SID_VIDEO_LAST    = 8'hef;
  localparam logic [7:0] SUBID_AUDIO_FIRST = 8'h80;
  localparam logic [7:0] SUBID_AUDIO_LAST  = 8'hbf;
  localparam logic [7:0] NO_STAMPS         = 8'h0f;
  localparam logic [7:0] STUFFING          = 8'hff;

  // pes flag bits kept by the predictor
  localparam logic [7:0] FLAG_PTS   = 8'h80;
  localparam logic [7:0] FLAG_DTS   = 8'h40;
  localparam logic [7:0] MPEG2_MARK = 8'h01;

  localparam int HOLD_AT     = 250;     // accepted bytes before the long receiver stall
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LIMIT   = 400000;  // time units, many times the slowest correct run

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'd0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [16:0]  cfg_data = 17'd0;

  mpeg_ps_pes_header_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bytes waiting to be offered, and records the parser still owes us
  logic [7:0] stream_bytes[$];
  result_t    due_records[$];

  int send_idle_pct = 18;
  int recv_idle_pct = 65;
  int errors = 0;
  int bytes_in = 0;
  bit byte_taken = 1'b0;

  // predictor copy of the parser state and of sync_limit
  logic [16:0] limit_reg     = SYNC_LIMIT_RESET;
  logic [23:0] win24         = WINDOW_RESET;
  logic [16:0] bytes_scanned = 17'd0;
  phase_t      pstate        = PH_SEARCH;
  logic [15:0] pkt_left      = 16'd0;
  logic [7:0]  hdr_left      = 8'd0;
  logic [7:0]  flags         = 8'd0;
  logic [3:0]  ts_idx        = 4'd0;
  logic [32:0] pts_build     = 33'd0;
  logic [32:0] dts_build     = 33'd0;
  logic [8:0]  code          = 9'd0;
  result_t     next_rec;

  function automatic void restart_search();
    pstate = PH_SEARCH;
    win24 = WINDOW_RESET;
    bytes_scanned = 17'd0;
  endfunction

  // one timestamp byte into the 33-bit accumulator; marker bits dropped
  function automatic logic [32:0] stamp_shift(logic [32:0] acc, logic [2:0] idx,
                                               logic [7:0] b);
    case (idx)
      3'd0: return {30'd0, b[3:1]};
      3'd1, 3'd3: return {acc[24:0], b};
      default: return {acc[25:0], b[7:1]};
    endcase
  endfunction

  function automatic bit emit_header_rec();
    next_rec = '0;
    next_rec.kind = KIND_HEADER;
    next_rec.stream_id = code[7:0];
    next_rec.is_substream = !code[8];
    next_rec.pts_valid = flags[7];
    next_rec.dts_valid = flags[7];
    next_rec.pts = flags[7] ? pts_build : 33'd0;
    next_rec.dts = flags[7] ? dts_build : 33'd0;
    next_rec.payload_length = pkt_left;
    next_rec.last = (pkt_left == 16'd0);
    if (pkt_left == 16'd0) restart_search();
    else pstate = PH_PAYLOAD;
    return 1'b1;
  endfunction

  // private-1 still needs its substream id before the record goes out
  function automatic bit finish_header();
    if (code == {1'b1, SID_PRIVATE_1}) begin
      if (pkt_left == 16'd0) restart_search();
      else pstate = PH_SUBID;
      return 1'b0;
    end
    return emit_header_rec();
  endfunction

  function automatic bit after_stamps();
    int unsigned need;
    if ((flags & MPEG2_MARK) != 8'd0) begin
      need = flags[6] ? 10 : (flags[7] ? 5 : 0);
      if (hdr_left < need) begin
        restart_search();
        return 1'b0;
      end
      hdr_left = hdr_left - 8'(need);
      if (hdr_left != 8'd0) begin
        pstate = PH_M2SKIP;
        return 1'b0;
      end
    end
    return finish_header();
  endfunction

  // first non-stuffing byte of the header, or the byte after the buffer fields
  function automatic bit classify_byte(logic [7:0] c, bit buf_ok);
    int unsigned need;
    if (buf_ok && c[7:6] == 2'b01) begin
      if (pkt_left < 2) begin
        restart_search();
        return 1'b0;
      end
      pkt_left = pkt_left - 16'd2;
      pstate = PH_BUF1;
      return 1'b0;
    end
    if (c[7:5] == 3'b001) begin
      need = c[4] ? 9 : 4;
      if (pkt_left < need) begin
        restart_search();
        return 1'b0;
      end
      pkt_left = pkt_left - 16'(need);
      flags = c[4] ? (FLAG_PTS | FLAG_DTS) : FLAG_PTS;
      pts_build = stamp_shift(33'd0, 3'd0, c);
      ts_idx = 4'd1;
      pstate = PH_PTS;
      return 1'b0;
    end
    if (c[7:6] == 2'b10) begin
      pstate = PH_M2FLAGS;
      return 1'b0;
    end
    if (c == NO_STAMPS) begin
      flags = 8'd0;
      return finish_header();
    end
    restart_search();
    return 1'b0;
  endfunction

  // advances the predictor by one stream byte; 1 when a record is due in next_rec
  function automatic bit parse_byte(logic [7:0] b);
    int unsigned lim;
    bit hit;
    lim = (limit_reg == 17'd0) ? 1 : limit_reg;
    case (pstate)
      PH_SEARCH: begin
        hit = (win24 == START_PREFIX);
        win24 = {win24[15:0], b};
        bytes_scanned = bytes_scanned + 17'd1;
        if (hit) begin
          code = {1'b1, b};
          if (code == {1'b1, SID_PADDING} || code == {1'b1, SID_PRIVATE_2})
            pstate = PH_SKIPLEN_H;
          else if ((code >= {1'b1, SID_AUDIO_FIRST} && code <= {1'b1, SID_VIDEO_LAST}) ||
                   code == {1'b1, SID_PRIVATE_1})
            pstate = PH_LEN_H;
          else
            restart_search();
          return 1'b0;
        end
        if (bytes_scanned >= lim) begin
          next_rec = '0;
          next_rec.kind = KIND_SYNC_LOST;
          restart_search();
          return 1'b1;
        end
      end
      PH_SKIPLEN_H: pstate = PH_SKIPLEN_L;
      PH_SKIPLEN_L: restart_search();
      PH_LEN_H: begin
        pkt_left = {b, 8'd0};
        pstate = PH_LEN_L;
      end
      PH_LEN_L: begin
        pkt_left = pkt_left | {8'd0, b};
        flags = 8'd0;
        if (pkt_left == 16'd0) restart_search();
        else pstate = PH_STUFF;
      end
      PH_STUFF: begin
        pkt_left = pkt_left - 16'd1;
        if (b == STUFFING) begin
          if (pkt_left == 16'd0) restart_search();
          return 1'b0;
        end
        return classify_byte(b, 1'b1);
      end
      PH_BUF1: pstate = PH_BUF2;
      PH_BUF2: return classify_byte(b, 1'b0);
      PH_M2FLAGS: begin
        // only 10 and 11 in the top bits bring timestamps
        flags = (b[7] ? {b[7:6], 6'd0} : 8'd0) | MPEG2_MARK;
        pstate = PH_M2HLEN;
      end
      PH_M2HLEN: begin
        if (pkt_left < 16'd2 || {8'd0, b} > pkt_left - 16'd2) begin
          restart_search();
          return 1'b0;
        end
        pkt_left = pkt_left - 16'd2 - {8'd0, b};
        hdr_left = b;
        if (flags[7]) begin
          ts_idx = 4'd0;
          pstate = PH_PTS;
          return 1'b0;
        end
        return after_stamps();
      end
      PH_PTS: begin
        pts_build = stamp_shift(pts_build, ts_idx[2:0], b);
        ts_idx = ts_idx + 4'd1;
        if (ts_idx < 4'd5) return 1'b0;
        if (flags[6]) begin
          ts_idx = 4'd0;
          pstate = PH_DTS;
          return 1'b0;
        end
        dts_build = pts_build;
        return after_stamps();
      end
      PH_DTS: begin
        dts_build = stamp_shift(dts_build, ts_idx[2:0], b);
        ts_idx = ts_idx + 4'd1;
        if (ts_idx < 4'd5) return 1'b0;
        return after_stamps();
      end
      PH_M2SKIP: begin
        hdr_left = hdr_left - 8'd1;
        if (hdr_left == 8'd0) return finish_header();
      end
      PH_SUBID: begin
        pkt_left = pkt_left - 16'd1;
        code = {1'b0, b};
        if (b >= SUBID_AUDIO_FIRST && b <= SUBID_AUDIO_LAST) begin
          if (pkt_left < 16'd3) begin
            restart_search();
            return 1'b0;
          end
          pkt_left = pkt_left - 16'd3;
          ts_idx = 4'd0;
          pstate = PH_SUBSKIP;
          return 1'b0;
        end
        return emit_header_rec();
      end
      PH_SUBSKIP: begin
        ts_idx = ts_idx + 4'd1;
        if (ts_idx >= 4'd3) return emit_header_rec();
      end
      PH_PAYLOAD: begin
        pkt_left = pkt_left - 16'd1;
        next_rec = '0;
        next_rec.kind = KIND_PAYLOAD;
        next_rec.stream_id = code[7:0];
        next_rec.is_substream = !code[8];
        next_rec.payload_byte = b;
        next_rec.last = (pkt_left == 16'd0);
        if (pkt_left == 16'd0) restart_search();
        return 1'b1;
      end
      default: restart_search();
    endcase
    return 1'b0;
  endfunction

  task automatic compare_field(string fname, logic [32:0] want_v, logic [32:0] seen_v);
    if (want_v !== seen_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want_v, seen_v);
    end
  endtask

  // monitor: predicts on every accepted byte, checks every accepted result
  always @(posedge clk) begin
    result_t want;
    byte_taken = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        byte_taken = 1'b1;
        bytes_in++;
        if (parse_byte(s_axis_tdata)) due_records.push_back(next_rec);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_records.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, got tuser %h tdata %h tlast %b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          want = due_records.pop_front();
          compare_field("kind", 33'(want.kind), 33'(m_axis_tuser[1:0]));
          compare_field("is_substream", 33'(want.is_substream), 33'(m_axis_tuser[2]));
          compare_field("stream_id", 33'(want.stream_id), 33'(m_axis_tdata[7:0]));
          compare_field("pts", want.pts, m_axis_tdata[40:8]);
          compare_field("dts", want.dts, m_axis_tdata[73:41]);
          compare_field("pts_valid", 33'(want.pts_valid), 33'(m_axis_tdata[74]));
          compare_field("dts_valid", 33'(want.dts_valid), 33'(m_axis_tdata[75]));
          compare_field("payload_length", 33'(want.payload_length),
                        33'(m_axis_tdata[91:76]));
          compare_field("payload_byte", 33'(want.payload_byte), 33'(m_axis_tdata[99:92]));
          compare_field("pad", 33'd0, 33'(m_axis_tdata[103:100]));
          compare_field("last", 33'(want.last), 33'(m_axis_tlast));
        end
      end
    end
  end

  // driver: offers the next queued byte once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stream_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold so the parser backs up to its input
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && bytes_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_start(logic [7:0] sid);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
    stream_bytes.push_back(sid);
  endtask

  // random bytes leaning toward 00 and 01 so stray prefixes show up
  task automatic add_noise(int n);
    repeat (n) begin
      if ($urandom_range(3) == 0) stream_bytes.push_back(8'($urandom_range(1)));
      else stream_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // other start codes, mostly ones the parser skips over
  task automatic add_other_code();
    logic [7:0] sid;
    case ($urandom_range(5))
      0: sid = SID_PACK;
      1: sid = SID_SYSTEM;
      2: sid = SID_MAP;
      3: sid = SID_PADDING;
      4: sid = SID_PRIVATE_2;
      default: sid = 8'($urandom_range(255));
    endcase
    push_start(sid);
    if (sid == SID_PADDING || sid == SID_PRIVATE_2) add_noise(2);
    add_noise($urandom_range(6));
  endtask

  // audio, video or private-1 packet, mostly well formed
  task automatic add_pes();
    logic [7:0] body[$];
    logic [7:0] sid;
    logic [7:0] flag_b;
    int need;
    int hlen;
    int npay;
    int len;
    case ($urandom_range(2))
      0: sid = SID_AUDIO_FIRST + 8'($urandom_range(31));
      1: sid = SID_VIDEO_FIRST + 8'($urandom_range(15));
      default: sid = SID_PRIVATE_1;
    endcase
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) body.push_back(STUFFING);
    if ($urandom_range(1)) begin
      // mpeg-2 header, sometimes with a header length too short for its stamps
      flag_b = 8'($urandom_range(255));
      need = flag_b[7] ? (flag_b[6] ? 10 : 5) : 0;
      hlen = ($urandom_range(9) == 0) ? $urandom_range(need) : need + $urandom_range(3);
      body.push_back(8'h80 | 8'($urandom_range(63)));
      body.push_back(flag_b);
      body.push_back(8'(hlen));
      repeat (hlen) body.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(2) == 0) begin
        body.push_back(8'h40 | 8'($urandom_range(63)));
        body.push_back(8'($urandom_range(255)));
      end
      case ($urandom_range(7))
        0, 1: body.push_back(NO_STAMPS);
        2, 3, 4: begin
          body.push_back(8'h20 | 8'($urandom_range(15)));
          repeat (4) body.push_back(8'($urandom_range(255)));
        end
        5, 6: begin
          body.push_back(8'h30 | 8'($urandom_range(15)));
          repeat (9) body.push_back(8'($urandom_range(255)));
        end
        default: body.push_back(8'($urandom_range(255)));
      endcase
    end
    if (sid == SID_PRIVATE_1) begin
      if ($urandom_range(1)) begin
        body.push_back(SUBID_AUDIO_FIRST + 8'($urandom_range(63)));
        repeat (3) body.push_back(8'($urandom_range(255)));
      end else begin
        body.push_back(8'($urandom_range(255)));
      end
    end
    npay = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 12);
    len = body.size() + npay;
    case ($urandom_range(11))
      0: len = $urandom_range(len);          // underrun somewhere in the header
      1: len = len + $urandom_range(1, 4);   // payload runs into the next bytes
      default: ;
    endcase
    push_start(sid);
    stream_bytes.push_back(len[15:8]);
    stream_bytes.push_back(len[7:0]);
    foreach (body[i]) stream_bytes.push_back(body[i]);
    repeat (npay) stream_bytes.push_back(8'($urandom_range(255)));
  endtask

  // waits until everything is sent and answered, then for a byte still in flight
  task automatic wait_idle();
    while (stream_bytes.size() != 0 || s_axis_tvalid || due_records.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sync_limit(logic [16:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [16:0] lim, int snd, int rcv, int nbytes);
    wait_idle();
    write_sync_limit(lim);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    while (stream_bytes.size() < nbytes) begin
      case ($urandom_range(9))
        0: add_noise(($urandom_range(9) == 0) ? 70 : $urandom_range(1, 8));
        1: add_other_code();
        default: add_pes();
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, at the reset sync_limit
    // empty video packet: header record that is also the last item
    push_start(SID_VIDEO_FIRST);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
    stream_bytes.push_back(NO_STAMPS);
    // padding packet, length bytes skipped
    push_start(SID_PADDING);
    stream_bytes.push_back(8'hff);
    stream_bytes.push_back(8'h00);
    // private-1 with a plain substream id and one payload byte
    push_start(SID_PRIVATE_1);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h03);
    stream_bytes.push_back(NO_STAMPS);
    stream_bytes.push_back(8'h20);
    stream_bytes.push_back(8'hff);

    // smallest limit: every scanned byte reports sync lost
    wait_idle();
    write_sync_limit(17'd1);
    add_noise(12);
    // zero behaves as one
    wait_idle();
    write_sync_limit(17'd0);
    add_noise(12);

    run_phase(17'd60, 18, 65, 380);
    // four is the tightest limit that still lets a start code through
    run_phase(17'd4, 65, 18, 380);
    run_phase(17'h1ffff, 0, 0, 380);

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
